// ===== hdl/bnns_pkg.sv =====
package bnns_pkg;

  // Field widths fixed by the interface
  localparam int DIST_W      = 32;
  localparam int ID_FIELD_W  = 16;
  localparam int RANK_W      = 4;
  localparam int COUNT_W     = 5;
  localparam int LIMIT_W     = 5;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 2;

  // Parameter defaults
  localparam int MAX_KEPT_DEF = 16;
  localparam int ID_BITS_DEF  = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_SQ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID    = 2'd2;

  // Configuration reset values
  localparam logic [DIST_W-1:0]     RADIUS_SQ_RST = 32'hFFFF_FFFF;
  localparam logic [LIMIT_W-1:0]    LIMIT_RST     = 5'd10;
  localparam logic [ID_FIELD_W-1:0] OWN_ID_RST    = 16'd0;

  // Per-cycle command broadcast to every cell of the row
  typedef struct packed {
    logic insert;  // sorted insert of the offered entry
    logic rotate;  // readout: shift kept entries toward the head, wrap head to tail
  } bnns_ctrl_t;

endpackage

// ===== hdl/bnns_cell.sv =====
module bnns_cell import bnns_pkg::*; #(
  parameter int IdW = ID_BITS_DEF
) (
  input  logic              clk_i,
  input  bnns_ctrl_t        ctrl_i,
  input  logic              occ_i,
  input  logic              tail_i,
  input  logic [DIST_W-1:0] new_dist_i,
  input  logic [IdW-1:0]    new_id_i,
  input  logic [DIST_W-1:0] left_dist_i,
  input  logic [IdW-1:0]    left_id_i,
  input  logic              left_moves_i,
  input  logic [DIST_W-1:0] right_dist_i,
  input  logic [IdW-1:0]    right_id_i,
  input  logic [DIST_W-1:0] head_dist_i,
  input  logic [IdW-1:0]    head_id_i,
  output logic [DIST_W-1:0] dist_o,
  output logic [IdW-1:0]    id_o,
  output logic              moves_o,
  output logic [DIST_W-1:0] tail_dist_o
);

  logic [DIST_W-1:0] dist_q, dist_d;
  logic [IdW-1:0]    id_q, id_d;

  // An empty slot or a strictly larger entry gives way to the offer;
  // equal distances stay ahead, so the newest lands behind them.
  always_comb begin
    dist_d  = dist_q;
    id_d    = id_q;
    moves_o = !occ_i || (dist_q > new_dist_i);
    if (ctrl_i.insert && moves_o) begin
      if (left_moves_i) begin
        dist_d = left_dist_i;
        id_d   = left_id_i;
      end else begin
        dist_d = new_dist_i;
        id_d   = new_id_i;
      end
    end else if (ctrl_i.rotate) begin
      if (tail_i) begin
        dist_d = head_dist_i;
        id_d   = head_id_i;
      end else begin
        dist_d = right_dist_i;
        id_d   = right_id_i;
      end
    end
  end

  // Post-insert distance of the tail slot, for the bound select
  assign tail_dist_o = tail_i ? dist_d : '0;

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
    id_q   <= id_d;
  end

  assign dist_o = dist_q;
  assign id_o   = id_q;

endmodule

// ===== hdl/bounded_nearest_neighbor_select.sv =====
// Keeps the nearest objects offered during one query in a row of MAX_KEPT
// compare-and-shift cells, sorted by squared distance (unsigned Q16.16).
// An offer is inserted when taken: every cell compares against the offer in
// parallel and the row shifts by one behind the insertion point, and the
// new bound is picked from the post-insert tail slot in the same cycle, so
// back-to-back offers run at one per cycle outside a readout. An offer
// flagged last_of_query starts a readout: the row rotates its kept entries
// toward the head, one result per cycle as the output register frees (a
// single invalid result for an empty list), and the input is stalled for
// that run. After the run the list is intact, so an offer without the
// first flag joins it. Configuration writes are always
// taken (ready is constant high); write only while the block is idle.
module bounded_nearest_neighbor_select import bnns_pkg::*; #(
  parameter int MAX_KEPT = MAX_KEPT_DEF,
  parameter int ID_BITS  = ID_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // offer channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  first_of_query_i,
  input  logic                  last_of_query_i,
  input  logic [ID_FIELD_W-1:0] object_id_i,
  input  logic [DIST_W-1:0]     distance_sq_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  entry_valid_o,
  output logic [ID_FIELD_W-1:0] neighbor_id_o,
  output logic [DIST_W-1:0]     neighbor_distance_sq_o,
  output logic [RANK_W-1:0]     rank_o,
  output logic [COUNT_W-1:0]    kept_count_o,
  output logic                  last_entry_o
);

  localparam int CntW = $clog2(MAX_KEPT + 1);
  localparam int LimW = ((CntW > LIMIT_W) ? CntW : LIMIT_W) + 1;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e                state_q;
  logic [CntW-1:0]       rd_idx_q;
  logic [CntW-1:0]       total_q;
  logic [DIST_W-1:0]     bound_q;
  logic [DIST_W-1:0]     radius_q;
  logic [LIMIT_W-1:0]    limit_q;
  logic [ID_FIELD_W-1:0] own_id_q;

  logic                  out_valid_q;
  logic                  entry_valid_q;
  logic [ID_FIELD_W-1:0] neighbor_id_q;
  logic [DIST_W-1:0]     neighbor_dist_q;
  logic [RANK_W-1:0]     rank_q;
  logic [COUNT_W-1:0]    kept_count_q;
  logic                  last_entry_q;

  logic                  in_acc, first_acc, take, drop, load_ok, rd_last;
  logic [CntW-1:0]       eff_total;
  logic [DIST_W-1:0]     eff_bound;
  logic [ID_BITS-1:0]    id_m, own_m;
  logic [LimW-1:0]       lim_raw, lim_eff, total_inc;
  logic [DIST_W-1:0]     sel_dist;
  bnns_ctrl_t            ctrl;

  logic [DIST_W-1:0]  cell_dist [MAX_KEPT];
  logic [ID_BITS-1:0] cell_id   [MAX_KEPT];
  logic               cell_mv   [MAX_KEPT];
  logic [DIST_W-1:0]  tail_dist [MAX_KEPT];

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q == S_READ);

  // Offer qualification
  assign in_acc    = in_valid_i && !in_stall_o;
  assign first_acc = in_acc && first_of_query_i;
  assign eff_total = first_acc ? '0 : total_q;
  assign eff_bound = first_acc ? radius_q : bound_q;
  assign id_m      = ID_BITS'(object_id_i);
  assign own_m     = ID_BITS'(own_id_q);
  assign take      = in_acc && (id_m != own_m) && (distance_sq_i < eff_bound);

  // Limit clamped to 1..MAX_KEPT; drop one entry when the count overflows it
  assign lim_raw = LimW'(limit_q);
  always_comb begin
    priority if (lim_raw == '0) begin
      lim_eff = LimW'(1);
    end else if (lim_raw > LimW'(MAX_KEPT)) begin
      lim_eff = LimW'(MAX_KEPT);
    end else begin
      lim_eff = lim_raw;
    end
  end
  assign total_inc = LimW'(eff_total) + LimW'(1);
  assign drop      = total_inc > lim_eff;

  // Readout handshake with the output register
  assign load_ok = !out_valid_q || !out_stall_i;
  assign rd_last = (rd_idx_q + CntW'(1)) == total_q;

  assign ctrl.insert = take;
  assign ctrl.rotate = (state_q == S_READ) && load_ok && (total_q != '0);

  // Row of cells
  for (genvar k = 0; k < MAX_KEPT; k++) begin : g_cell
    logic [DIST_W-1:0]  left_dist, right_dist;
    logic [ID_BITS-1:0] left_id, right_id;
    logic               left_mv;

    if (k == 0) begin : g_head
      assign left_dist = distance_sq_i;
      assign left_id   = id_m;
      assign left_mv   = 1'b0;
    end else begin : g_body
      assign left_dist = cell_dist[k-1];
      assign left_id   = cell_id[k-1];
      assign left_mv   = cell_mv[k-1];
    end

    if (k == MAX_KEPT - 1) begin : g_end
      assign right_dist = '0;
      assign right_id   = '0;
    end else begin : g_mid
      assign right_dist = cell_dist[k+1];
      assign right_id   = cell_id[k+1];
    end

    bnns_cell #(
      .IdW (ID_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occ_i        (CntW'(k) < eff_total),
      .tail_i       (CntW'(k + 1) == eff_total),
      .new_dist_i   (distance_sq_i),
      .new_id_i     (id_m),
      .left_dist_i  (left_dist),
      .left_id_i    (left_id),
      .left_moves_i (left_mv),
      .right_dist_i (right_dist),
      .right_id_i   (right_id),
      .head_dist_i  (cell_dist[0]),
      .head_id_i    (cell_id[0]),
      .dist_o       (cell_dist[k]),
      .id_o         (cell_id[k]),
      .moves_o      (cell_mv[k]),
      .tail_dist_o  (tail_dist[k])
    );
  end

  // Largest kept distance after an overflowing insert
  always_comb begin
    sel_dist = '0;
    for (int k = 0; k < MAX_KEPT; k++) begin
      sel_dist = sel_dist | tail_dist[k];
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_SQ_RST;
      limit_q  <= LIMIT_RST;
      own_id_q <= OWN_ID_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_RADIUS_SQ: radius_q <= cfg_data_i;
        CFG_LIMIT:     limit_q  <= LIMIT_W'(cfg_data_i);
        CFG_OWN_ID:    own_id_q <= ID_FIELD_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Kept count and bound
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      bound_q <= RADIUS_SQ_RST;
    end else if (take) begin
      total_q <= drop ? eff_total : eff_total + CntW'(1);
      bound_q <= drop ? sel_dist : eff_bound;
    end else if (first_acc) begin
      total_q <= '0;
      bound_q <= radius_q;
    end
  end

  // Readout sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      rd_idx_q        <= '0;
      out_valid_q     <= 1'b0;
      entry_valid_q   <= 1'b0;
      neighbor_id_q   <= '0;
      neighbor_dist_q <= '0;
      rank_q          <= '0;
      kept_count_q    <= '0;
      last_entry_q    <= 1'b0;
    end else begin
      // output register reloads or empties whenever it is free
      if (load_ok) begin
        out_valid_q <= (state_q == S_READ);
      end
      unique case (state_q)
        S_IDLE: begin
          rd_idx_q <= '0;
          if (in_acc && last_of_query_i) begin
            state_q <= S_READ;
          end
        end
        S_READ: begin
          if (load_ok) begin
            kept_count_q <= COUNT_W'(total_q);
            rank_q       <= RANK_W'(rd_idx_q);
            if (total_q == '0) begin
              // empty list: one invalid result
              entry_valid_q   <= 1'b0;
              neighbor_id_q   <= '0;
              neighbor_dist_q <= '0;
              last_entry_q    <= 1'b1;
              state_q         <= S_IDLE;
            end else begin
              entry_valid_q   <= 1'b1;
              neighbor_id_q   <= ID_FIELD_W'(cell_id[0]);
              neighbor_dist_q <= cell_dist[0];
              last_entry_q    <= rd_last;
              rd_idx_q        <= rd_idx_q + CntW'(1);
              if (rd_last) begin
                state_q <= S_IDLE;
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o            = out_valid_q;
  assign entry_valid_o          = entry_valid_q;
  assign neighbor_id_o          = neighbor_id_q;
  assign neighbor_distance_sq_o = neighbor_dist_q;
  assign rank_o                 = rank_q;
  assign kept_count_o           = kept_count_q;
  assign last_entry_o           = last_entry_q;

endmodule

// ===== hdl/bnns_checker.sv =====
module bnns_checker import bnns_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  last_of_query_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic                  entry_valid_o,
  input logic [ID_FIELD_W-1:0] neighbor_id_o,
  input logic [DIST_W-1:0]     neighbor_distance_sq_o,
  input logic [RANK_W-1:0]     rank_o,
  input logic [COUNT_W-1:0]    kept_count_o,
  input logic                  last_entry_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(neighbor_id_o) &&
      $stable(neighbor_distance_sq_o) && $stable(rank_o) && $stable(last_entry_o))
    else $error("stalled result changed");

  // The input only stalls after a transfer that closes a query
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && last_of_query_i))
    else $error("input stalled without a last-of-query transfer");

  // The empty-list result is the only one of its run
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !entry_valid_o |-> last_entry_o && (kept_count_o == '0))
    else $error("invalid result inside a readout run");

  // The closing result carries the highest rank
  a_last_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && entry_valid_o && last_entry_o |->
      kept_count_o[RANK_W-1:0] == rank_o + RANK_W'(1))
    else $error("last rank does not match kept count");

  // A readout run streams without gaps
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_entry_o |=> out_valid_o)
    else $error("gap inside a readout run");

endmodule

bind bounded_nearest_neighbor_select bnns_checker u_bnns_checker (.*);

// ===== bench/bounded_nearest_neighbor_select_tb.sv =====
`timescale 1ns / 100ps

module bounded_nearest_neighbor_select_tb;
  import bnns_pkg::*;

  // Index with no register behind it; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int PHASES = 8;
  localparam int PHASE_OFFERS = 36;

  typedef struct packed {
    logic                  entry_valid;
    logic [ID_FIELD_W-1:0] neighbor_id;
    logic [DIST_W-1:0]     distance_sq;
    logic [RANK_W-1:0]     rank;
    logic [COUNT_W-1:0]    kept_count;
    logic                  last_entry;
  } neighbor_res_t;

  // One directed offer; the t_* fields hold a single typed-in readout
  typedef struct packed {
    logic                  first;
    logic                  last;
    logic [ID_FIELD_W-1:0] id;
    logic [DIST_W-1:0]     dsq;
    logic                  typed;
    logic                  t_valid;
    logic [ID_FIELD_W-1:0] t_id;
    logic [DIST_W-1:0]     t_dist;
    logic [COUNT_W-1:0]    t_count;
  } offer_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic                  first_of_query_i = 1'b0;
  logic                  last_of_query_i = 1'b0;
  logic [ID_FIELD_W-1:0] object_id_i = '0;
  logic [DIST_W-1:0]     distance_sq_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  entry_valid_o;
  logic [ID_FIELD_W-1:0] neighbor_id_o;
  logic [DIST_W-1:0]     neighbor_distance_sq_o;
  logic [RANK_W-1:0]     rank_o;
  logic [COUNT_W-1:0]    kept_count_o;
  logic                  last_entry_o;

  // Typed-in expectation, carried alongside the offer payload
  logic          typed_item = 1'b0;
  neighbor_res_t typed_res = '0;

  // Predictor state and its copy of the registers
  logic [DIST_W-1:0]     kept_dist_m [0:MAX_KEPT_DEF];
  logic [ID_FIELD_W-1:0] kept_id_m [0:MAX_KEPT_DEF];
  int                    kept_n_m = 0;
  logic [DIST_W-1:0]     bound_m = RADIUS_SQ_RST;
  logic [DIST_W-1:0]     radius_m = RADIUS_SQ_RST;
  logic [LIMIT_W-1:0]    limit_m = LIMIT_RST;
  logic [ID_FIELD_W-1:0] own_m = OWN_ID_RST;

  neighbor_res_t expected_neighbors [$];
  int            error_count = 0;
  int            offers_sent = 0;

  // Stimulus knobs
  int                    send_idle_pct = 0;
  int                    recv_idle_pct = 0;
  int                    stall_left = 0;
  logic [DIST_W-1:0]     cur_radius = RADIUS_SQ_RST;
  logic [ID_FIELD_W-1:0] cur_own = OWN_ID_RST;
  logic [DIST_W-1:0]     radius_set [PHASES];
  logic [LIMIT_W-1:0]    limit_set [PHASES];
  logic [ID_FIELD_W-1:0] own_set [PHASES];

  // Default config: limit 10, own id 0, radius at max
  offer_row_t directed_rows [24] = '{
    // after reset, no first flag: joins the empty list
    '{1'b0, 1'b1, 16'h0007, 32'h0000_0009, 1'b1, 1'b1, 16'h0007, 32'h0000_0009, 5'd1},
    // own id is skipped: empty readout
    '{1'b1, 1'b1, 16'h0000, 32'h0000_0005, 1'b1, 1'b0, 16'h0000, 32'h0000_0000, 5'd0},
    '{1'b1, 1'b1, 16'h1234, 32'h0000_0000, 1'b1, 1'b1, 16'h1234, 32'h0000_0000, 5'd1},
    // equal to the bound: skipped
    '{1'b1, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 16'h0000, 32'h0000_0000, 5'd0},
    '{1'b1, 1'b1, 16'hFFFF, 32'hFFFF_FFFE, 1'b1, 1'b1, 16'hFFFF, 32'hFFFF_FFFE, 5'd1},
    // ties land behind older entries
    '{1'b1, 1'b0, 16'h0001, 32'd100, 1'b0, 1'b0, 16'h0, 32'h0, 5'd0},
    '{1'b0, 1'b0, 16'h0002, 32'd50, 1'b0, 1'b0, 16'h0, 32'h0, 5'd0},
    '{1'b0, 1'b0, 16'h0003, 32'd100, 1'b0, 1'b0, 16'h0, 32'h0, 5'd0},
    '{1'b0, 1'b0, 16'h0000, 32'd10, 1'b0, 1'b0, 16'h0, 32'h0, 5'd0},
    '{1'b0, 1'b1, 16'h0004, 32'd0, 1'b0, 1'b0, 16'h0, 32'h0, 5'd0},
    // list survives the readout
    '{1'b0, 1'b1, 16'h0005, 32'd75, 1'b0, 1'b0, 16'h0, 32'h0, 5'd0},
    // overfill past the limit, bound drops to the largest kept
    '{1'b1, 1'b0, 16'h0101, 32'h0003_0000, 1'b0, 1'b0, 16'h0, 32'h0, 5'd0},
    '{1'b0, 1'b0, 16'h0102, 32'h0001_0000, 1'b0, 1'b0, 16'h0, 32'h0, 5'd0},
    '{1'b0, 1'b0, 16'h0103, 32'h0005_0000, 1'b0, 1'b0, 16'h0, 32'h0, 5'd0},
    '{1'b0, 1'b0, 16'h0104, 32'h0002_0000, 1'b0, 1'b0, 16'h0, 32'h0, 5'd0},
    '{1'b0, 1'b0, 16'h0105, 32'h0005_0000, 1'b0, 1'b0, 16'h0, 32'h0, 5'd0},
    '{1'b0, 1'b0, 16'h0106, 32'h0004_0000, 1'b0, 1'b0, 16'h0, 32'h0, 5'd0},
    '{1'b0, 1'b0, 16'h0107, 32'h0006_0000, 1'b0, 1'b0, 16'h0, 32'h0, 5'd0},
    '{1'b0, 1'b0, 16'h0108, 32'h0007_0000, 1'b0, 1'b0, 16'h0, 32'h0, 5'd0},
    '{1'b0, 1'b0, 16'h0109, 32'h0008_0000, 1'b0, 1'b0, 16'h0, 32'h0, 5'd0},
    '{1'b0, 1'b0, 16'h010A, 32'h0009_0000, 1'b0, 1'b0, 16'h0, 32'h0, 5'd0},
    '{1'b0, 1'b0, 16'h010B, 32'h0000_5000, 1'b0, 1'b0, 16'h0, 32'h0, 5'd0},
    '{1'b0, 1'b0, 16'h0200, 32'h0008_0000, 1'b0, 1'b0, 16'h0, 32'h0, 5'd0},
    '{1'b0, 1'b1, 16'hABCD, 32'h0007_FFFF, 1'b0, 1'b0, 16'h0, 32'h0, 5'd0}
  };

  bounded_nearest_neighbor_select dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_o            (cfg_ready_o),
    .cfg_index_i            (cfg_index_i),
    .cfg_data_i             (cfg_data_i),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .first_of_query_i       (first_of_query_i),
    .last_of_query_i        (last_of_query_i),
    .object_id_i            (object_id_i),
    .distance_sq_i          (distance_sq_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .entry_valid_o          (entry_valid_o),
    .neighbor_id_o          (neighbor_id_o),
    .neighbor_distance_sq_o (neighbor_distance_sq_o),
    .rank_o                 (rank_o),
    .kept_count_o           (kept_count_o),
    .last_entry_o           (last_entry_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Append one expected result at the back of the queue
  task automatic queue_expected(input neighbor_res_t r);
    expected_neighbors.insert(expected_neighbors.size(), r);
  endtask

  // Sorted insert of one offer, then the readout if it closes the query
  task automatic predict_offer(input logic first, input logic last,
                               input logic [ID_FIELD_W-1:0] id,
                               input logic [DIST_W-1:0] dsq, input logic emit);
    int slot;
    int lim;
    neighbor_res_t r;
    if (first) begin
      kept_n_m = 0;
      bound_m = radius_m;
    end
    lim = (limit_m == 0) ? 1 : ((limit_m > MAX_KEPT_DEF) ? MAX_KEPT_DEF : int'(limit_m));
    if (id != own_m && dsq < bound_m) begin
      slot = 0;
      while (slot < kept_n_m && kept_dist_m[slot] <= dsq) slot++;
      for (int k = kept_n_m; k > slot; k--) begin
        kept_dist_m[k] = kept_dist_m[k-1];
        kept_id_m[k] = kept_id_m[k-1];
      end
      kept_dist_m[slot] = dsq;
      kept_id_m[slot] = id;
      kept_n_m++;
      // over the limit: drop the tail, which becomes the new bound
      if (kept_n_m > lim) begin
        kept_n_m--;
        bound_m = kept_dist_m[kept_n_m-1];
      end
    end
    if (last && emit) begin
      r = '0;
      if (kept_n_m == 0) begin
        r.last_entry = 1'b1;
        queue_expected(r);
      end
      for (int k = 0; k < kept_n_m; k++) begin
        r.entry_valid = 1'b1;
        r.neighbor_id = kept_id_m[k];
        r.distance_sq = kept_dist_m[k];
        r.rank = k[RANK_W-1:0];
        r.kept_count = kept_n_m[COUNT_W-1:0];
        r.last_entry = (k + 1 == kept_n_m);
        queue_expected(r);
      end
    end
  endtask

  task automatic compare_result(input neighbor_res_t want);
    if (entry_valid_o !== want.entry_valid) begin
      $error("entry_valid: expected %0d, got %0d", want.entry_valid, entry_valid_o);
      error_count++;
    end
    if (neighbor_id_o !== want.neighbor_id) begin
      $error("neighbor_id: expected %h, got %h", want.neighbor_id, neighbor_id_o);
      error_count++;
    end
    if (neighbor_distance_sq_o !== want.distance_sq) begin
      $error("neighbor_distance_sq: expected %h, got %h", want.distance_sq,
             neighbor_distance_sq_o);
      error_count++;
    end
    if (rank_o !== want.rank) begin
      $error("rank: expected %0d, got %0d", want.rank, rank_o);
      error_count++;
    end
    if (kept_count_o !== want.kept_count) begin
      $error("kept_count: expected %0d, got %0d", want.kept_count, kept_count_o);
      error_count++;
    end
    if (last_entry_o !== want.last_entry) begin
      $error("last_entry: expected %0d, got %0d", want.last_entry, last_entry_o);
      error_count++;
    end
  endtask

  // Monitor: results first, then register writes, then offers
  always @(posedge clk_i) begin : transfer_monitor
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_neighbors.size() == 0) begin
          $error("result transfer with none expected: id %h distance %h",
                 neighbor_id_o, neighbor_distance_sq_o);
          error_count++;
        end else begin
          compare_result(expected_neighbors.pop_front());
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_RADIUS_SQ: radius_m = cfg_data_i;
          CFG_LIMIT:     limit_m = cfg_data_i[LIMIT_W-1:0];
          CFG_OWN_ID:    own_m = cfg_data_i[ID_FIELD_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        predict_offer(first_of_query_i, last_of_query_i, object_id_i, distance_sq_i,
                      !typed_item);
        if (typed_item) queue_expected(typed_res);
      end
    end
  end

  // Receiver stalls in random bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      if ($urandom_range(0, 99) < recv_idle_pct) stall_left <= $urandom_range(1, 19);
    end
  end

  // Offer transfer; valid stays high afterwards so offers can run back to back
  task automatic drive_offer(input logic first, input logic last,
                             input logic [ID_FIELD_W-1:0] id,
                             input logic [DIST_W-1:0] dsq,
                             input logic typed, input neighbor_res_t want);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    first_of_query_i <= first;
    last_of_query_i <= last;
    object_id_i <= id;
    distance_sq_i <= dsq;
    typed_item <= typed;
    typed_res <= want;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    offers_sent++;
  endtask

  // Drop valid and wait until every expected result has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_neighbors.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes all registers in one burst of transfers; block must be idle
  task automatic apply_settings(input logic [DIST_W-1:0] radius,
                                input logic [LIMIT_W-1:0] lim,
                                input logic [ID_FIELD_W-1:0] own);
    logic [31:0] noise;
    cfg_valid_i <= 1'b1;
    for (int k = 0; k < 4; k++) begin
      noise = $urandom;
      case (k)
        0: begin
          cfg_index_i <= CFG_RADIUS_SQ;
          cfg_data_i <= radius;
        end
        1: begin
          cfg_index_i <= CFG_LIMIT;
          cfg_data_i <= {noise[31:LIMIT_W], lim};
        end
        2: begin
          cfg_index_i <= CFG_OWN_ID;
          cfg_data_i <= {noise[31:ID_FIELD_W], own};
        end
        default: begin
          cfg_index_i <= CFG_SPARE;
          cfg_data_i <= noise;
        end
      endcase
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    cur_radius = radius;
    cur_own = own;
  endtask

  function automatic logic [ID_FIELD_W-1:0] pick_id();
    int unsigned sel;
    logic [31:0] w;
    sel = $urandom_range(0, 19);
    w = $urandom;
    if (sel < 2) return cur_own;
    if (sel == 2) return '0;
    if (sel == 3) return '1;
    return w[ID_FIELD_W-1:0];
  endfunction

  // Mix of tiny values (ties), full range, extremes and values under the radius
  function automatic logic [DIST_W-1:0] pick_distance();
    int unsigned sel;
    logic [31:0] w;
    sel = $urandom_range(0, 19);
    w = $urandom;
    if (sel < 7) return {28'h0, w[3:0]};
    if (sel < 13) return w;
    if (sel == 13) return '0;
    if (sel == 14) return '1;
    if (sel == 15) return cur_radius;
    if (sel == 16) return cur_radius - 1;
    return (cur_radius == 0) ? w : w % cur_radius;
  endfunction

  task automatic run_query(input int len, input logic with_first, input logic with_last);
    for (int i = 0; i < len; i++)
      drive_offer(with_first && i == 0, with_last && i == len - 1, pick_id(),
                  pick_distance(), 1'b0, '0);
  endtask

  initial begin : stimulus
    neighbor_res_t want;
    int phase_start;
    int len;
    int kind;
    logic [31:0] w;

    // Phase settings: extremes first, then random ones
    radius_set[0] = '1;  limit_set[0] = 5'd16; own_set[0] = '0;
    radius_set[1] = '0;  limit_set[1] = 5'd1;  own_set[1] = '1;
    radius_set[2] = $urandom; limit_set[2] = 5'd0;  own_set[2] = ID_FIELD_W'($urandom);
    radius_set[3] = '1;  limit_set[3] = 5'd31; own_set[3] = ID_FIELD_W'($urandom);
    w = $urandom;
    radius_set[4] = {1'b1, w[30:0]}; limit_set[4] = 5'd16;
    own_set[4] = ID_FIELD_W'($urandom);
    // lowered limit while the query from the phase before is still open
    radius_set[5] = $urandom; limit_set[5] = 5'd3; own_set[5] = ID_FIELD_W'($urandom);
    radius_set[6] = $urandom; limit_set[6] = LIMIT_W'($urandom_range(0, 31));
    own_set[6] = ID_FIELD_W'($urandom);
    radius_set[7] = $urandom; limit_set[7] = LIMIT_W'($urandom_range(1, 16));
    own_set[7] = ID_FIELD_W'($urandom);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table at reset settings
    send_idle_pct = 25;
    recv_idle_pct = 15;
    foreach (directed_rows[i]) begin
      want = '{directed_rows[i].t_valid, directed_rows[i].t_id, directed_rows[i].t_dist,
               '0, directed_rows[i].t_count, 1'b1};
      drive_offer(directed_rows[i].first, directed_rows[i].last, directed_rows[i].id,
                  directed_rows[i].dsq, directed_rows[i].typed, want);
    end
    drain();

    // Random phases, one register setting each
    for (int p = 0; p < PHASES; p++) begin
      apply_settings(radius_set[p], limit_set[p], own_set[p]);
      send_idle_pct = (p == PHASES - 1) ? 0 : $urandom_range(0, 40);
      recv_idle_pct = (p == PHASES - 1) ? 0 : $urandom_range(0, 25);
      phase_start = offers_sent;
      if (p == 5) run_query(6, 1'b0, 1'b1);
      while (offers_sent - phase_start < PHASE_OFFERS) begin
        kind = $urandom_range(0, 9);
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
        case (kind)
          0: drive_offer(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_id(),
                         pick_distance(), 1'b0, '0);
          1: run_query(len, 1'b1, 1'b0);
          2: run_query(len, 1'b0, 1'b1);
          default: run_query(len, 1'b1, 1'b1);
        endcase
        if ($urandom_range(0, 15) == 0) drain();
      end
      // leave a query open across the next register change
      if (p == 4) run_query(14, 1'b1, 1'b0);
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("bounded_nearest_neighbor_select_tb OK");
    end else begin
      $display("bounded_nearest_neighbor_select_tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("bounded_nearest_neighbor_select_tb NOT OK");
    $finish;
  end

endmodule
